### rtl/core/qtl_pkg.sv
// Shared constants for the query text lexer: token kinds, position widths and
// the bilingual keyword table. No dependencies.
`default_nettype none

package qtl_pkg;

  localparam int MAX_KEYWORD_BYTES = 26;
  localparam int POSITION_BITS = 16;
  localparam int KW_VEC_W = 8 * MAX_KEYWORD_BYTES;
  localparam int COUNT_W = $clog2(MAX_KEYWORD_BYTES + 1);
  localparam int KIND_W = 6;
  localparam int FIELD_W = 16;
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_END = 6'd0;
  localparam logic [KIND_W-1:0] KIND_IDENT = 6'd1;
  localparam logic [KIND_W-1:0] KIND_PARAM = 6'd2;
  localparam logic [KIND_W-1:0] KIND_STRING = 6'd3;
  localparam logic [KIND_W-1:0] KIND_NUMBER = 6'd4;
  localparam logic [KIND_W-1:0] KIND_OPERATOR = 6'd5;
  localparam logic [KIND_W-1:0] KIND_DOT = 6'd6;
  localparam logic [KIND_W-1:0] KIND_COMMA = 6'd7;
  localparam logic [KIND_W-1:0] KIND_LPAREN = 6'd8;
  localparam logic [KIND_W-1:0] KIND_RPAREN = 6'd9;
  localparam logic [KIND_W-1:0] KIND_SEMICOLON = 6'd10;

  // Words are stored right-aligned, first byte highest, zero above the word.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [KW_VEC_W-1:0] word;
  } kw_entry_t;

  localparam int KW_COUNT = 74;

  localparam kw_entry_t KW_TABLE [KW_COUNT] = '{
    '{6'd11, 208'("SELECT")}, '{6'd11, 208'hD092D0ABD091D0A0D090D0A2D0AC},
    '{6'd12, 208'("FROM")}, '{6'd12, 208'hD098D097},
    '{6'd13, 208'("AS")}, '{6'd13, 208'hD09AD090D09A},
    '{6'd14, 208'("LEFT")}, '{6'd14, 208'hD09BD095D092D09ED095},
    '{6'd15, 208'("RIGHT")}, '{6'd15, 208'hD09FD0A0D090D092D09ED095},
    '{6'd16, 208'("INNER")}, '{6'd16, 208'hD092D09DD0A3D0A2D0A0D095D09DD09DD095D095},
    '{6'd17, 208'("FULL")}, '{6'd17, 208'hD09FD09ED09BD09DD09ED095},
    '{6'd18, 208'("JOIN")}, '{6'd18, 208'hD0A1D09ED095D094D098D09DD095D09DD098D095},
    '{6'd19, 208'("UNION")}, '{6'd19, 208'hD09ED091D0AAD095D094D098D09DD098D0A2D0AC},
    '{6'd20, 208'("ALL")}, '{6'd20, 208'hD092D0A1D095},
    '{6'd21, 208'("INTO")}, '{6'd21, 208'hD09FD09ED09CD095D0A1D0A2D098D0A2D0AC},
    '{6'd22, 208'("DESTROY")}, '{6'd22, 208'hD0A3D09DD098D0A7D0A2D09ED096D098D0A2D0AC},
    '{6'd23, 208'("ISNULL")}, '{6'd23, 208'hD095D0A1D0A2D0AC4E554C4C},
    '{6'd24, 208'("CAST")}, '{6'd24, 208'hD092D0ABD0A0D090D097D098D0A2D0AC},
    '{6'd25, 208'("PRESENTATION")},
    '{6'd25, 208'hD09FD0A0D095D094D0A1D0A2D090D092D09BD095D09DD098D095},
    '{6'd26, 208'("CASE")}, '{6'd26, 208'hD092D0ABD091D09ED0A0},
    '{6'd27, 208'("WHEN")}, '{6'd27, 208'hD09AD09ED093D094D090},
    '{6'd28, 208'("THEN")}, '{6'd28, 208'hD0A2D09ED093D094D090},
    '{6'd29, 208'("ELSE")}, '{6'd29, 208'hD098D09DD090D0A7D095},
    '{6'd30, 208'("END")}, '{6'd30, 208'hD09AD09ED09DD095D0A6},
    '{6'd31, 208'("DISTINCT")}, '{6'd31, 208'hD0A0D090D097D09BD098D0A7D09DD0ABD095},
    '{6'd32, 208'("ALLOWED")}, '{6'd32, 208'hD0A0D090D097D0A0D095D0A8D095D09DD09DD0ABD095},
    '{6'd33, 208'("TOP")}, '{6'd33, 208'hD09FD095D0A0D092D0ABD095},
    '{6'd34, 208'("WHERE")}, '{6'd34, 208'hD093D094D095},
    '{6'd35, 208'("GROUP")},
    '{6'd35, 208'hD0A1D093D0A0D0A3D09FD09FD098D0A0D09ED092D090D0A2D0AC},
    '{6'd36, 208'("ORDER")}, '{6'd36, 208'hD0A3D09FD09ED0A0D0AFD094D09ED0A7D098D0A2D0AC},
    '{6'd37, 208'hD09FD09E},
    '{6'd38, 208'("BY")},
    '{6'd39, 208'("ON")},
    '{6'd40, 208'("HAVING")}, '{6'd40, 208'hD098D09CD095D0AED0A9D098D095},
    '{6'd41, 208'("TOTALS")}, '{6'd41, 208'hD098D0A2D09ED093D098},
    '{6'd42, 208'("AND")}, '{6'd42, 208'hD098},
    '{6'd43, 208'("OR")}, '{6'd43, 208'hD098D09BD098},
    '{6'd44, 208'("NOT")}, '{6'd44, 208'hD09DD095},
    '{6'd45, 208'("IN")}, '{6'd45, 208'hD092},
    '{6'd46, 208'("NULL")},
    '{6'd47, 208'("TRUE")}, '{6'd47, 208'hD098D0A1D0A2D098D09DD090},
    '{6'd48, 208'("FALSE")}, '{6'd48, 208'hD09BD09ED096D0AC},
    '{6'd49, 208'("REFS")}, '{6'd49, 208'hD0A1D0A1D0ABD09BD09AD090}
  };

  // Byte length of a stored word; every word starts with a nonzero byte.
  function automatic logic [COUNT_W-1:0] kw_len(input logic [KW_VEC_W-1:0] w);
    logic [COUNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_KEYWORD_BYTES; i++) begin
      if (w[8*i +: 8] != 8'h00) begin
        n = COUNT_W'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### rtl/core/qtl_byte_if.sv
// Input channel of the query text lexer: one text byte per request.
// Depends on nothing.
`default_nettype none

interface qtl_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

`default_nettype wire

### rtl/core/qtl_token_if.sv
// Output channel of the query text lexer: one token per request.
// Depends on qtl_pkg for field widths.
`default_nettype none

interface qtl_token_if;
  logic                         valid;
  logic                         ready;
  logic [qtl_pkg::KIND_W-1:0]   token_kind;
  logic [qtl_pkg::FIELD_W-1:0]  token_offset;
  logic [qtl_pkg::FIELD_W-1:0]  token_length;
  logic                         run_last;

  modport source (output valid, output token_kind, output token_offset,
                  output token_length, output run_last, input ready);
  modport sink (input valid, input token_kind, input token_offset,
                input token_length, input run_last, output ready);
endinterface

`default_nettype wire

### rtl/core/query_text_lexer.sv
// Query text lexer top level: byte-wise scanner, keyword match and token queue.
// Depends on qtl_pkg, qtl_byte_if and qtl_token_if.
//
//   channel  | dir | payload                                           | per request
//   text     | in  | text_byte, final_byte                             | one byte
//   tokens   | out | token_kind, token_offset, token_length, run_last  | one token
//
// A byte is scanned in the cycle it is taken; its tokens (zero to three) land in a
// three-entry result queue and leave one per cycle while the token sink is ready. A new
// byte is taken while the queue is empty or holds one token that leaves in the same
// cycle, so a byte yielding several tokens holds off the next byte until they drain.
// Keyword match is a parallel compare against the constant table at flush time.
// Synchronous reset returns the scanner to idle and empties the queue.
`default_nettype none

module query_text_lexer (
  input  wire logic     clk,
  input  wire logic     rst,
  qtl_byte_if.sink      text,
  qtl_token_if.source   tokens
);

  localparam int PW = qtl_pkg::POSITION_BITS;
  localparam int VW = qtl_pkg::KW_VEC_W;
  localparam int CW = qtl_pkg::COUNT_W;
  localparam int KW = qtl_pkg::KIND_W;
  localparam int FW = qtl_pkg::FIELD_W;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_PARAM, M_NUMBER, M_STRING, M_QUOTE, M_ANGLE
  } mode_t;

  typedef struct packed {
    logic [VW-1:0] vec;
    logic [CW-1:0] count;
    logic          ovf;
    logic [7:0]    lead;
  } match_t;

  function automatic match_t put_byte(input match_t s, input logic [7:0] b);
    match_t r;
    r = s;
    if (int'(s.count) < qtl_pkg::MAX_KEYWORD_BYTES) begin
      r.vec = {s.vec[VW-9:0], b};
      r.count = s.count + CW'(1);
    end else begin
      r.ovf = 1'b1;
    end
    return r;
  endfunction

  function automatic match_t feed(input match_t s, input logic [7:0] b);
    match_t r;
    logic [7:0] l;
    r = s;
    if (s.lead != 8'h00) begin
      l = s.lead;
      r.lead = 8'h00;
      if (l == 8'hD0 && b >= 8'hB0 && b <= 8'hBF) begin
        return put_byte(put_byte(r, 8'hD0), b - 8'h20);
      end
      if (l == 8'hD1 && b >= 8'h80 && b <= 8'h8F) begin
        return put_byte(put_byte(r, 8'hD0), b + 8'h20);
      end
      if (l == 8'hD1 && b >= 8'h90 && b <= 8'h9F) begin
        return put_byte(put_byte(r, 8'hD0), b - 8'h10);
      end
      r = put_byte(r, l);
    end
    if (b == 8'hD0 || b == 8'hD1) begin
      r.lead = b;
      return r;
    end
    if (b >= "a" && b <= "z") begin
      return put_byte(r, b - 8'h20);
    end
    return put_byte(r, b);
  endfunction

  function automatic logic [KW-1:0] lookup(input match_t s0);
    match_t s;
    logic [KW-1:0] k;
    logic [CW-1:0] len;
    logic [VW-1:0] mask;
    s = s0;
    if (s.lead != 8'h00) begin
      s = put_byte(s, s.lead);
    end
    k = qtl_pkg::KIND_IDENT;
    if (!s.ovf) begin
      for (int i = 0; i < qtl_pkg::KW_COUNT; i++) begin
        len = qtl_pkg::kw_len(qtl_pkg::KW_TABLE[i].word);
        mask = ~({VW{1'b1}} << (8 * int'(len)));
        if (s.count == len && (s.vec & mask) == qtl_pkg::KW_TABLE[i].word) begin
          k = qtl_pkg::KW_TABLE[i].kind;
        end
      end
    end
    return k;
  endfunction

  function automatic logic [KW-1:0] flush_kind(input mode_t m, input logic [KW-1:0] kw);
    logic [KW-1:0] k;
    case (m)
      M_IDENT:  k = kw;
      M_PARAM:  k = qtl_pkg::KIND_PARAM;
      M_NUMBER: k = qtl_pkg::KIND_NUMBER;
      M_STRING: k = qtl_pkg::KIND_STRING;
      M_QUOTE:  k = qtl_pkg::KIND_STRING;
      M_ANGLE:  k = qtl_pkg::KIND_OPERATOR;
      default:  k = qtl_pkg::KIND_END;
    endcase
    return k;
  endfunction

  // Scanner state
  mode_t         mode, mode_next;
  logic          quote_dbl, quote_dbl_next;
  logic [PW-1:0] pos, pos_next;
  logic [PW-1:0] tbeg, tbeg_next;
  match_t        ids, ids_next;

  // Result queue, head at entry 0
  logic [KW-1:0] q_kind [3];
  logic [FW-1:0] q_off  [3];
  logic [FW-1:0] q_len  [3];
  logic          q_last [3];
  logic [1:0]    q_cnt;

  logic [KW-1:0] e_kind [3];
  logic [FW-1:0] e_off  [3];
  logic [FW-1:0] e_len  [3];
  logic [1:0]    ne;

  logic [7:0]    b;
  logic          fin;
  logic [PW-1:0] nxt;
  logic [7:0]    quote;
  logic          is_digit, is_alpha, ident_b, is_space, is_op;
  logic          cont, fresh, start_ident;
  logic [KW-1:0] kw;
  logic          take_in, take_out;
  logic          flush_a;
  logic [PW-1:0] end_a;

  assign b = text.text_byte;
  assign fin = text.final_byte;
  assign nxt = (pos == qtl_pkg::POS_MAX) ? pos : pos + PW'(1);
  assign quote = quote_dbl ? 8'h22 : 8'h27;
  assign is_digit = (b >= "0" && b <= "9");
  assign is_alpha = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  assign ident_b = is_digit || is_alpha || b == "_" || b == "#" || b >= 8'h80;
  assign is_space = (b == " ") || (b >= 8'd9 && b <= 8'd13);
  assign is_op = b == "+" || b == "-" || b == "*" || b == "/" || b == "=" || b == "%";

  // Whether the byte extends the open token rather than starting fresh.
  assign cont = ((mode == M_IDENT || mode == M_PARAM) && ident_b)
             || (mode == M_NUMBER && (is_digit || b == "."))
             || (mode == M_STRING)
             || (mode == M_QUOTE && b == quote)
             || (mode == M_ANGLE && (b == "=" || b == ">"));
  assign fresh = !cont;
  assign start_ident = fresh && ident_b && !is_digit;

  always_comb begin
    ids_next = ids;
    if (mode == M_IDENT && ident_b) begin
      ids_next = feed(ids, b);
    end else if (start_ident) begin
      ids_next = feed('{vec: ids.vec, count: '0, ovf: 1'b0, lead: 8'h00}, b);
    end
  end

  assign kw = lookup(ids_next);

  always_comb begin
    mode_next = mode;
    quote_dbl_next = quote_dbl;
    tbeg_next = tbeg;
    pos_next = nxt;
    ne = 2'd0;
    flush_a = 1'b0;
    end_a = pos;
    for (int i = 0; i < 3; i++) begin
      e_kind[i] = '0;
      e_off[i] = '0;
      e_len[i] = '0;
    end

    case (mode)
      M_IDENT, M_PARAM, M_NUMBER: flush_a = fresh;
      M_STRING: begin
        if (b == quote) begin
          mode_next = M_QUOTE;
        end
      end
      M_QUOTE: begin
        if (b == quote) begin
          mode_next = M_STRING;
        end else begin
          flush_a = 1'b1;
        end
      end
      M_ANGLE: begin
        flush_a = 1'b1;
        if (cont) begin
          end_a = nxt;
        end
      end
      default: mode_next = M_IDLE;
    endcase

    if (flush_a) begin
      e_kind[ne] = flush_kind(mode, kw);
      e_off[ne] = FW'(tbeg);
      e_len[ne] = FW'(end_a - tbeg);
      ne = ne + 2'd1;
      mode_next = M_IDLE;
    end

    if (fresh && !is_space) begin
      if (b == "." || b == "," || b == "(" || b == ")" || b == ";") begin
        case (b)
          ".":     e_kind[ne] = qtl_pkg::KIND_DOT;
          ",":     e_kind[ne] = qtl_pkg::KIND_COMMA;
          "(":     e_kind[ne] = qtl_pkg::KIND_LPAREN;
          ")":     e_kind[ne] = qtl_pkg::KIND_RPAREN;
          default: e_kind[ne] = qtl_pkg::KIND_SEMICOLON;
        endcase
        e_off[ne] = FW'(pos);
        e_len[ne] = FW'(1);
        ne = ne + 2'd1;
      end else begin
        tbeg_next = pos;
        if (b == "&") begin
          mode_next = M_PARAM;
        end else if (b == 8'h27 || b == 8'h22) begin
          mode_next = M_STRING;
          quote_dbl_next = (b == 8'h22);
        end else if (is_digit) begin
          mode_next = M_NUMBER;
        end else if (b == "<" || b == ">") begin
          mode_next = M_ANGLE;
        end else if (ident_b && !is_op) begin
          mode_next = M_IDENT;
        end else begin
          e_kind[ne] = qtl_pkg::KIND_OPERATOR;
          e_off[ne] = FW'(pos);
          e_len[ne] = FW'(1);
          ne = ne + 2'd1;
        end
      end
    end

    // The last byte closes any open token and appends the end marker.
    if (fin) begin
      if (mode_next != M_IDLE) begin
        e_kind[ne] = flush_kind(mode_next, kw);
        e_off[ne] = FW'(tbeg_next);
        e_len[ne] = FW'(nxt - tbeg_next);
        ne = ne + 2'd1;
      end
      e_kind[ne] = qtl_pkg::KIND_END;
      e_off[ne] = FW'(nxt);
      e_len[ne] = '0;
      ne = ne + 2'd1;
      mode_next = M_IDLE;
      quote_dbl_next = 1'b0;
      pos_next = '0;
      tbeg_next = '0;
    end
  end

  assign text.ready = (q_cnt == 2'd0) || (q_cnt == 2'd1 && tokens.ready);
  assign take_in = text.valid && text.ready;
  assign take_out = tokens.valid && tokens.ready;

  assign tokens.valid = (q_cnt != 2'd0);
  assign tokens.token_kind = q_kind[0];
  assign tokens.token_offset = q_off[0];
  assign tokens.token_length = q_len[0];
  assign tokens.run_last = q_last[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      quote_dbl <= 1'b0;
      pos <= '0;
      tbeg <= '0;
      ids.count <= '0;
      ids.ovf <= 1'b0;
      ids.lead <= 8'h00;
      q_cnt <= 2'd0;
    end else if (take_in) begin
      mode <= mode_next;
      quote_dbl <= quote_dbl_next;
      pos <= pos_next;
      tbeg <= tbeg_next;
      ids.vec <= ids_next.vec;
      if (fin) begin
        ids.count <= '0;
        ids.ovf <= 1'b0;
        ids.lead <= 8'h00;
      end else begin
        ids.count <= ids_next.count;
        ids.ovf <= ids_next.ovf;
        ids.lead <= ids_next.lead;
      end
      for (int i = 0; i < 3; i++) begin
        q_kind[i] <= e_kind[i];
        q_off[i] <= e_off[i];
        q_len[i] <= e_len[i];
        q_last[i] <= (2'(i) == ne - 2'd1);
      end
      q_cnt <= ne;
    end else if (take_out) begin
      for (int i = 0; i < 2; i++) begin
        q_kind[i] <= q_kind[i+1];
        q_off[i] <= q_off[i+1];
        q_len[i] <= q_len[i+1];
        q_last[i] <= q_last[i+1];
      end
      q_cnt <= q_cnt - 2'd1;
    end
  end

  a_final_resets: assert property (@(posedge clk) disable iff (rst)
    (take_in && fin) |=> (mode == M_IDLE && pos == '0 && tbeg == '0))
    else $error("scanner state not cleared after the last byte");

  a_end_is_last: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && tokens.token_kind == qtl_pkg::KIND_END) |-> tokens.run_last)
    else $error("end token is not the last token of its byte");

  a_more_follow: assert property (@(posedge clk) disable iff (rst)
    (tokens.valid && !tokens.run_last) |=> tokens.valid)
    else $error("token run broken before its last token");

endmodule

`default_nettype wire

### dv/testbench.sv
// Self-checking testbench for query_text_lexer: streams query bytes, predicts
// the token stream in a scoreboard class and checks every token field.
// Depends on qtl_pkg, qtl_byte_if, qtl_token_if and the lexer itself.
`default_nettype none

module testbench;

  localparam int LIMIT_CYCLES = 200000;
  localparam int KDW = qtl_pkg::KIND_W;
  localparam int FW = qtl_pkg::FIELD_W;
  localparam int PW = qtl_pkg::POSITION_BITS;
  localparam int VW = qtl_pkg::KW_VEC_W;
  localparam int MAXB = qtl_pkg::MAX_KEYWORD_BYTES;

  typedef logic [7:0] octet_t;

  typedef struct {
    logic [KDW-1:0] kind;
    logic [FW-1:0]  offset;
    logic [FW-1:0]  length;
    logic           last;
  } token_t;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_IDENT, SCAN_PARAM, SCAN_NUMBER, SCAN_STRING, SCAN_QUOTE, SCAN_ANGLE
  } scan_mode_t;

  class token_scoreboard;
    token_t expected_tokens[$];
    int errors;
    int tokens_checked;
    int keywords_seen;
    scan_mode_t mode;
    bit dbl_quote;
    logic [PW-1:0] pos;
    logic [PW-1:0] tok_start;
    octet_t fold_buf[MAXB];
    int fold_count;
    bit fold_overflow;
    octet_t lead;

    function new();
      errors = 0;
      tokens_checked = 0;
      keywords_seen = 0;
      clear();
    endfunction

    function void clear();
      mode = SCAN_IDLE;
      dbl_quote = 0;
      pos = '0;
      tok_start = '0;
      fold_count = 0;
      fold_overflow = 0;
      lead = 8'h00;
    endfunction

    function bit is_digit(octet_t b);
      return b >= "0" && b <= "9";
    endfunction

    function bit is_word_byte(octet_t b);
      return is_digit(b) || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") ||
             b == "_" || b == "#" || b >= 8'h80;
    endfunction

    function void put(octet_t b);
      if (fold_count < MAXB) begin
        fold_buf[fold_count] = b;
        fold_count++;
      end else begin
        fold_overflow = 1;
      end
    endfunction

    // Folds lower-case Cyrillic pairs and ASCII letters into upper case.
    function void fold(octet_t b);
      octet_t ld;
      if (lead != 8'h00) begin
        ld = lead;
        lead = 8'h00;
        if (ld == 8'hD0 && b >= 8'hB0 && b <= 8'hBF) begin
          put(8'hD0); put(b - 8'h20); return;
        end
        if (ld == 8'hD1 && b >= 8'h80 && b <= 8'h8F) begin
          put(8'hD0); put(b + 8'h20); return;
        end
        if (ld == 8'hD1 && b >= 8'h90 && b <= 8'h9F) begin
          put(8'hD0); put(b - 8'h10); return;
        end
        put(ld);
      end
      if (b == 8'hD0 || b == 8'hD1) begin
        lead = b;
        return;
      end
      if (b >= "a" && b <= "z") b = b - 8'h20;
      put(b);
    endfunction

    function logic [KDW-1:0] word_kind();
      logic [VW-1:0] vec;
      if (lead != 8'h00) begin
        put(lead);
        lead = 8'h00;
      end
      if (fold_overflow) return qtl_pkg::KIND_IDENT;
      vec = '0;
      for (int i = 0; i < fold_count; i++) vec = {vec[VW-9:0], fold_buf[i]};
      // Folded bytes are never zero, so the right-aligned compare also checks length.
      for (int k = 0; k < qtl_pkg::KW_COUNT; k++) begin
        if (qtl_pkg::KW_TABLE[k].word == vec) begin
          keywords_seen++;
          return qtl_pkg::KW_TABLE[k].kind;
        end
      end
      return qtl_pkg::KIND_IDENT;
    endfunction

    function void push(logic [KDW-1:0] kind, logic [FW-1:0] off, logic [FW-1:0] len);
      token_t t;
      t.kind = kind;
      t.offset = off;
      t.length = len;
      t.last = 1'b0;
      expected_tokens.insert(expected_tokens.size(), t);
    endfunction

    function void close_token(logic [PW-1:0] stop);
      logic [FW-1:0] len;
      len = FW'(stop - tok_start);
      case (mode)
        SCAN_IDENT: push(word_kind(), tok_start, len);
        SCAN_PARAM: push(qtl_pkg::KIND_PARAM, tok_start, len);
        SCAN_NUMBER: push(qtl_pkg::KIND_NUMBER, tok_start, len);
        SCAN_STRING, SCAN_QUOTE: push(qtl_pkg::KIND_STRING, tok_start, len);
        SCAN_ANGLE: push(qtl_pkg::KIND_OPERATOR, tok_start, len);
        default: ;
      endcase
      mode = SCAN_IDLE;
    endfunction

    function void begin_token(octet_t b, logic [PW-1:0] p);
      if (b == " " || (b >= 8'd9 && b <= 8'd13)) return;
      case (b)
        ".": begin push(qtl_pkg::KIND_DOT, p, FW'(1)); return; end
        ",": begin push(qtl_pkg::KIND_COMMA, p, FW'(1)); return; end
        "(": begin push(qtl_pkg::KIND_LPAREN, p, FW'(1)); return; end
        ")": begin push(qtl_pkg::KIND_RPAREN, p, FW'(1)); return; end
        ";": begin push(qtl_pkg::KIND_SEMICOLON, p, FW'(1)); return; end
        default: ;
      endcase
      tok_start = p;
      if (b == "&") begin
        mode = SCAN_PARAM;
      end else if (b == "'" || b == "\"") begin
        mode = SCAN_STRING;
        dbl_quote = (b == "\"");
      end else if (is_digit(b)) begin
        mode = SCAN_NUMBER;
      end else if (b == "<" || b == ">") begin
        mode = SCAN_ANGLE;
      end else if (b == "+" || b == "-" || b == "*" || b == "/" || b == "=" || b == "%") begin
        push(qtl_pkg::KIND_OPERATOR, p, FW'(1));
      end else if (is_word_byte(b)) begin
        mode = SCAN_IDENT;
        fold_count = 0;
        fold_overflow = 0;
        lead = 8'h00;
        fold(b);
      end else begin
        push(qtl_pkg::KIND_OPERATOR, p, FW'(1));
      end
    endfunction

    function void note_request(octet_t b, bit fin);
      logic [PW-1:0] nxt;
      octet_t quote;
      bit fresh;
      int before_n;
      before_n = expected_tokens.size();
      nxt = (pos == qtl_pkg::POS_MAX) ? pos : pos + 1'b1;
      quote = dbl_quote ? "\"" : "'";
      fresh = 1;
      case (mode)
        SCAN_IDENT: if (is_word_byte(b)) begin fold(b); fresh = 0; end else close_token(pos);
        SCAN_PARAM: if (is_word_byte(b)) fresh = 0; else close_token(pos);
        SCAN_NUMBER: if (is_digit(b) || b == ".") fresh = 0; else close_token(pos);
        SCAN_STRING: begin
          if (b == quote) mode = SCAN_QUOTE;
          fresh = 0;
        end
        SCAN_QUOTE: if (b == quote) begin mode = SCAN_STRING; fresh = 0; end
                    else close_token(pos);
        SCAN_ANGLE: if (b == "=" || b == ">") begin close_token(nxt); fresh = 0; end
                    else close_token(pos);
        default: mode = SCAN_IDLE;
      endcase
      if (fresh) begin_token(b, pos);
      if (fin) begin
        close_token(nxt);
        push(qtl_pkg::KIND_END, nxt, '0);
        clear();
      end else begin
        pos = nxt;
      end
      if (expected_tokens.size() > before_n) expected_tokens[$].last = 1'b1;
    endfunction

    function void check(token_t got);
      token_t want;
      tokens_checked++;
      if (expected_tokens.size() == 0) begin
        $error("unexpected token kind=%0d offset=%0d", got.kind, got.offset);
        errors++;
        return;
      end
      want = expected_tokens.pop_front();
      if (got.kind !== want.kind) begin
        $error("token_kind: expected %0d, got %0d", want.kind, got.kind); errors++;
      end
      if (got.offset !== want.offset) begin
        $error("token_offset: expected %0d, got %0d", want.offset, got.offset); errors++;
      end
      if (got.length !== want.length) begin
        $error("token_length: expected %0d, got %0d", want.length, got.length); errors++;
      end
      if (got.last !== want.last) begin
        $error("run_last: expected %0d, got %0d", want.last, got.last); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int cycles = 0;
  int bytes_sent;
  int queries_sent;
  bit quiet_stretch;
  token_scoreboard sb;

  qtl_byte_if text ();
  qtl_token_if tokens ();

  query_text_lexer dut (
    .clk(clk),
    .rst(rst),
    .text(text.sink),
    .tokens(tokens.source)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function int draw_gap();
    return quiet_stretch ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic void append_byte(ref octet_t q[$], input octet_t b);
    q.insert(q.size(), b);
  endfunction

  task automatic send_byte(octet_t b, bit fin);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      text.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text.valid <= 1'b1;
    text.text_byte <= b;
    text.final_byte <= fin;
    do @(posedge clk); while (!text.ready);
    sb.note_request(b, fin);
    bytes_sent++;
  endtask

  task automatic send_query(octet_t q[$]);
    for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1);
    queries_sent++;
  endtask

  // Appends one keyword from the table, with random letter case.
  task automatic add_keyword(ref octet_t q[$]);
    qtl_pkg::kw_entry_t e;
    int len;
    octet_t b;
    octet_t nx;
    e = qtl_pkg::KW_TABLE[$urandom_range(0, qtl_pkg::KW_COUNT - 1)];
    len = 0;
    for (int i = 0; i < MAXB; i++) if (e.word[8*i +: 8] != 8'h00) len = i + 1;
    for (int j = 0; j < len; j++) begin
      b = e.word[8*(len-1-j) +: 8];
      if (b == 8'hD0 && j + 1 < len && $urandom_range(0, 1)) begin
        nx = e.word[8*(len-2-j) +: 8];
        if (nx >= 8'h90 && nx <= 8'h9F) begin
          append_byte(q, 8'hD0); append_byte(q, nx + 8'h20);
        end else if (nx >= 8'hA0 && nx <= 8'hAF) begin
          append_byte(q, 8'hD1); append_byte(q, nx - 8'h20);
        end else begin
          append_byte(q, 8'hD1); append_byte(q, nx + 8'h10);
        end
        j++;
      end else if (b >= "A" && b <= "Z" && $urandom_range(0, 1)) begin
        append_byte(q, b + 8'h20);
      end else begin
        append_byte(q, b);
      end
    end
  endtask

  function automatic octet_t word_char();
    case ($urandom_range(0, 5))
      0: return octet_t'($urandom_range("a", "z"));
      1: return octet_t'($urandom_range("A", "Z"));
      2: return octet_t'($urandom_range("0", "9"));
      3: return $urandom_range(0, 1) ? "_" : "#";
      default: return octet_t'($urandom_range(8'h80, 8'hFF));
    endcase
  endfunction

  task automatic add_piece(ref octet_t q[$], input bit closing);
    int n;
    octet_t qc;
    case ($urandom_range(0, 11))
      0, 1, 2: add_keyword(q);
      3, 4: begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(24, 32) : $urandom_range(1, 8);
        append_byte(q, $urandom_range(0, 1) ? "t" : "_");
        repeat (n - 1) append_byte(q, word_char());
      end
      5: repeat ($urandom_range(1, 6)) append_byte(q, $urandom_range(0, 3) ? word_char() : ".");
      6: begin
        qc = $urandom_range(0, 1) ? "\"" : "'";
        append_byte(q, qc);
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(0, 3) == 0) begin append_byte(q, qc); append_byte(q, qc); end
          else append_byte(q, octet_t'($urandom_range(0, 255)));
        end
        // A string left open is only allowed to run into the end of the query.
        if (!closing || $urandom_range(0, 1)) append_byte(q, qc);
      end
      7: begin
        append_byte(q, $urandom_range(0, 1) ? "<" : ">");
        case ($urandom_range(0, 3))
          0: append_byte(q, "=");
          1: append_byte(q, ">");
          2: append_byte(q, "<");
          default: ;
        endcase
      end
      8: begin
        append_byte(q, "&");
        repeat ($urandom_range(0, 6)) append_byte(q, word_char());
      end
      9: case ($urandom_range(0, 10))
           0: append_byte(q, "."); 1: append_byte(q, ","); 2: append_byte(q, "(");
           3: append_byte(q, ")"); 4: append_byte(q, ";"); 5: append_byte(q, "+");
           6: append_byte(q, "-"); 7: append_byte(q, "*"); 8: append_byte(q, "/");
           9: append_byte(q, "="); default: append_byte(q, "%");
         endcase
      10: append_byte(q, octet_t'($urandom_range(0, 255)));
      default: begin
        // Lead byte that may or may not pair up with a Cyrillic trail byte.
        append_byte(q, $urandom_range(0, 1) ? 8'hD0 : 8'hD1);
        append_byte(q, octet_t'($urandom_range(0, 255)));
      end
    endcase
  endtask

  // Token sink: ready is lowered for the drawn stall right after each accepted token.
  initial begin
    int stall;
    token_t got;
    tokens.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        tokens.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      tokens.ready <= 1'b1;
      do @(posedge clk); while (!tokens.valid);
      got.kind = tokens.token_kind;
      got.offset = tokens.token_offset;
      got.length = tokens.token_length;
      got.last = tokens.run_last;
      sb.check(got);
    end
  end

  initial begin
    octet_t q[$];
    string directed;
    sb = new();
    bytes_sent = 0;
    queries_sent = 0;
    quiet_stretch = 0;
    rst <= 1'b1;
    text.valid <= 1'b0;
    text.text_byte <= 8'h00;
    text.final_byte <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Short hand-written query: every token class but the dot, doubled quote, two-byte operators.
    directed = "SeLect a1,2.5<>&p 'x''y'(b>=c);";
    q.delete();
    for (int i = 0; i < directed.len(); i++) append_byte(q, directed[i]);
    append_byte(q, 8'hFF);
    send_query(q);
    q.delete();
    append_byte(q, 8'h00);
    send_query(q);

    while (bytes_sent < 460) begin
      quiet_stretch = ($urandom_range(0, 4) == 0);
      q.delete();
      repeat ($urandom_range(1, 10)) begin
        if ($urandom_range(0, 1)) begin
          append_byte(q, $urandom_range(0, 3) ? " " : octet_t'($urandom_range(9, 13)));
        end
        add_piece(q, 0);
      end
      add_piece(q, 1);
      if ($urandom_range(0, 3) == 0) append_byte(q, " ");
      send_query(q);
    end
    text.valid <= 1'b0;
    quiet_stretch = 0;

    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes in %0d queries; checked %0d tokens, %0d of them keywords.",
             bytes_sent, queries_sent, sb.tokens_checked, sb.keywords_seen);
    $display("Covered every token class, doubled quotes, broken UTF-8 and long identifiers.");
    if (sb.errors == 0 && sb.expected_tokens.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
